// File: design/skt_pkg.sv
package skt_pkg;

  // fixed field widths of the channels
  localparam int IN_KEY_W = 16;
  localparam int SLOT_W   = 8;
  localparam int COUNT_W  = 9;

  // widest key and address that any legal configuration needs
  localparam int EXT_W      = 32;
  localparam int ADDR_MAX_W = 12;

  localparam int unsigned SLOT_MAX  = 255;
  localparam int unsigned COUNT_MAX = 511;

  localparam logic CMD_CREATE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SHIFT,
    S_INS,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_MAX_W-1:0] wr_addr;
    logic [EXT_W-1:0]      wr_data;
    logic                  rd_en;
    logic [ADDR_MAX_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic               found;
    logic               created;
    logic [SLOT_W-1:0]  slot;
    logic               full_res;
    logic [COUNT_W-1:0] entry_count;
  } res_t;

endpackage

// File: design/skt_if.sv
interface skt_in_if;
  import skt_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [IN_KEY_W-1:0] key;

  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

interface skt_out_if;
  import skt_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic               created;
  logic [SLOT_W-1:0]  slot;
  logic               full_res;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, found, created, slot, full_res, entry_count, input ready);
  modport sink   (input valid, found, created, slot, full_res, entry_count, output ready);
endinterface

// File: design/skt_mem.sv
module skt_mem #(
  parameter int ENTRIES  = 256,
  parameter int KEY_BITS = 16
) (
  input  logic                clk,
  input  skt_pkg::mem_req_t   req,
  output logic [KEY_BITS-1:0] rd_data
);
  import skt_pkg::*;

  localparam int ADDR_W = $clog2(ENTRIES);

  logic [KEY_BITS-1:0] mem_r [ENTRIES];
  logic [KEY_BITS-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr[ADDR_W-1:0]] <= req.wr_data[KEY_BITS-1:0];
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr[ADDR_W-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/skt_ctrl.sv
module skt_ctrl #(
  parameter int ENTRIES  = 256,
  parameter int KEY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [KEY_BITS-1:0] in_key,
  output skt_pkg::mem_req_t   mem_req,
  input  logic [KEY_BITS-1:0] rd_data,
  output logic                done_valid,
  input  logic                done_ready,
  output skt_pkg::res_t       res
);
  import skt_pkg::*;

  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  state_t              state_r, state_nxt;
  logic                cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    src_r, src_nxt;
  logic [ADDR_W-1:0]   dst_r, dst_nxt;
  logic                pend_r, pend_nxt;
  logic                found_r, found_nxt;
  logic                created_r, created_nxt;
  logic                full_r, full_nxt;

  logic [CNT_W:0]      sum;
  logic [CNT_W-1:0]    mid;
  logic [CNT_W-1:0]    src_dec;
  logic                key_lt;
  logic                key_eq;
  logic                miss_create;
  logic [EXT_W-1:0]    lo_ext;
  logic [EXT_W-1:0]    cnt_ext;

  assign sum         = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid         = sum[CNT_W:1];
  assign src_dec     = src_r - 1'b1;
  // the one shared comparator
  assign key_lt      = rd_data < key_r;
  assign key_eq      = rd_data == key_r;
  assign miss_create = (cmd_r == CMD_CREATE) && !found_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (lo_r < hi_r) begin
          state_nxt = S_CMP;
        end else if (miss_create && (count_r != FULL_CNT)) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        state_nxt = S_RD;
      end
      S_SHIFT: begin
        if (src_r == lo_r) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    count_nxt   = count_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    pend_nxt    = pend_r;
    found_nxt   = found_r;
    created_nxt = created_r;
    full_nxt    = full_r;
    mem_req     = '0;
    in_ready    = 1'b0;
    done_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt     = in_cmd;
          key_nxt     = in_key;
          lo_nxt      = '0;
          hi_nxt      = count_r;
          found_nxt   = 1'b0;
          created_nxt = 1'b0;
          full_nxt    = 1'b0;
        end
      end
      S_RD: begin
        if (lo_r < hi_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_MAX_W'(mid[ADDR_W-1:0]);
        end else if (miss_create) begin
          if (count_r == FULL_CNT) begin
            full_nxt = 1'b1;
          end else begin
            src_nxt  = count_r;
            pend_nxt = 1'b0;
          end
        end
      end
      S_CMP: begin
        if (key_lt) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
        if (key_eq) begin
          found_nxt = 1'b1;
        end
      end
      S_SHIFT: begin
        // read entry src-1 while writing the previous one up by one place
        if (pend_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = ADDR_MAX_W'(dst_r);
          mem_req.wr_data = EXT_W'(rd_data);
        end
        if (src_r != lo_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_MAX_W'(src_dec[ADDR_W-1:0]);
          dst_nxt         = src_r[ADDR_W-1:0];
          pend_nxt        = 1'b1;
          src_nxt         = src_dec;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_INS: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ADDR_MAX_W'(lo_r[ADDR_W-1:0]);
        mem_req.wr_data = EXT_W'(key_r);
        count_nxt       = count_r + 1'b1;
        created_nxt     = 1'b1;
      end
      S_DONE: begin
        done_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    found_r   <= found_nxt;
    created_r <= created_nxt;
    full_r    <= full_nxt;
  end

  assign lo_ext  = EXT_W'(lo_r);
  assign cnt_ext = EXT_W'(count_r);

  always_comb begin
    res.found       = found_r;
    res.created     = created_r;
    res.full_res    = full_r;
    res.slot        = (lo_ext > SLOT_MAX) ? SLOT_W'(SLOT_MAX) : lo_ext[SLOT_W-1:0];
    res.entry_count = (cnt_ext > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : cnt_ext[COUNT_W-1:0];
  end

endmodule

// File: design/sorted_key_table_find_or_insert_core.sv
// Sorted key table with find-or-insert. Keeps up to ENTRIES unique keys of
// KEY_BITS bits in ascending order in a single-port-write, registered-read
// memory. Each input beat carries a key and a command (lookup, or lookup and
// create). A binary search built on one shared comparator reads the memory
// and then compares for each probe. A create of a missing key then shifts
// the larger keys up one place at one entry per cycle through the memory
// port, then writes the new key in its slot. A create into a full table
// stores nothing and sets full_res. One request is in the core at a time;
// the result beat sits in an output register, so the next request can be
// taken while the result waits. The memory needs no clearing after reset.
module sorted_key_table_find_or_insert_core #(
  parameter int ENTRIES  = 256,
  parameter int KEY_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  skt_in_if.sink   in_ch,
  skt_out_if.source out_ch
);
  import skt_pkg::*;

  logic [EXT_W-1:0]    key_ext;
  logic [KEY_BITS-1:0] key_used;
  mem_req_t            mem_req;
  logic [KEY_BITS-1:0] rd_data;
  logic                done_valid;
  logic                done_ready;
  res_t                res;

  logic                out_valid_r;
  res_t                out_res_r;

  // bits above KEY_BITS are ignored
  assign key_ext  = EXT_W'(in_ch.key);
  assign key_used = key_ext[KEY_BITS-1:0];

  // search and shift sequencer
  skt_ctrl #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_cmd     (in_ch.cmd),
    .in_key     (key_used),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .res        (res)
  );

  // key store
  skt_mem #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // output register: the finished beat waits here
  assign done_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_res_r.found;
  assign out_ch.created     = out_res_r.created;
  assign out_ch.slot        = out_res_r.slot;
  assign out_ch.full_res    = out_res_r.full_res;
  assign out_ch.entry_count = out_res_r.entry_count;

endmodule

// File: design/skt_checker.sv
module skt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_found,
  input logic                       out_created,
  input logic [skt_pkg::SLOT_W-1:0]  out_slot,
  input logic                       out_full_res,
  input logic [skt_pkg::COUNT_W-1:0] out_entry_count
);
  import skt_pkg::*;

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_found_xor_created: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_created))
    else $error("key both found and created");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> !out_found && !out_created)
    else $error("full flag with found or created");

  a_created_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_created |-> (COUNT_W'(out_slot) < out_entry_count))
    else $error("created slot not below entry count");

endmodule

bind sorted_key_table_find_or_insert_core skt_checker u_skt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found       (out_ch.found),
  .out_created     (out_ch.created),
  .out_slot        (out_ch.slot),
  .out_full_res    (out_ch.full_res),
  .out_entry_count (out_ch.entry_count)
);
